### rtl/crc32rv_pkg.sv
// Shared types, constants and the byte-wide CRC step of the record validator.
`timescale 1ns / 1ps
`default_nettype none

package crc32rv_pkg;

  localparam logic [31:0] RECORD_MAGIC      = 32'h5344_4950;
  localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;
  localparam logic [15:0] MIN_RECORD_LENGTH = 16'd12;
  localparam logic [15:0] HEADER_MAGIC_END  = 16'd3;
  localparam logic [15:0] HEADER_END        = 16'd7;
  localparam logic [15:0] HEADER_BYTES      = 16'd8;
  localparam logic [15:0] TRAILER_BYTES     = 16'd4;
  localparam int          CfgIndexWidth     = 2;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_EXPECTED_VERSION = 2'd0,
    CFG_RECORD_LENGTH    = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FAIL_NONE    = 3'd0,
    FAIL_MAGIC   = 3'd1,
    FAIL_VERSION = 3'd2,
    FAIL_LENGTH  = 3'd3,
    FAIL_CRC     = 3'd4
  } fail_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_record;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic [2:0]  fail_reason;
    logic [31:0] computed_crc;
  } out_item_t;

  // Configuration as seen by the checker; the length is already clamped.
  typedef struct packed {
    logic [15:0] expected_version;
    logic [15:0] record_length;
  } cfg_t;

  // One byte through the reflected CRC-32, LSB first.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/crc32rv_if.sv
// Valid/ready channel interfaces for record bytes and verdicts.
`timescale 1ns / 1ps
`default_nettype none

interface crc32rv_in_if;
  import crc32rv_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface crc32rv_out_if;
  import crc32rv_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/crc32rv_cfg.sv
// Configuration registers of the record validator, with the length clamp.
`timescale 1ns / 1ps
`default_nettype none

module crc32rv_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [crc32rv_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]                           cfg_data,
  output crc32rv_pkg::cfg_t                     cfg
);
  import crc32rv_pkg::*;

  logic [15:0] expected_version;
  logic [15:0] record_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= 16'd1;
      record_length    <= 16'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EXPECTED_VERSION: expected_version <= cfg_data;
        CFG_RECORD_LENGTH:    record_length    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Lengths below the smallest legal record count as the smallest one.
  always_comb begin
    cfg.expected_version = expected_version;
    cfg.record_length    = (record_length < MIN_RECORD_LENGTH) ? MIN_RECORD_LENGTH
                                                               : record_length;
  end

endmodule

`default_nettype wire

### rtl/crc32rv_check.sv
// Record state, CRC step, header checks and the verdict output register.
`timescale 1ns / 1ps
`default_nettype none

module crc32rv_check (
  input  logic                  clk,
  input  logic                  rst,
  input  crc32rv_pkg::cfg_t     cfg,
  input  logic                  item_valid,
  input  crc32rv_pkg::in_item_t item,
  output logic                  item_ready,
  crc32rv_out_if.source         verdict
);
  import crc32rv_pkg::*;

  logic [15:0] byte_count;
  logic [31:0] crc_reg;
  logic [31:0] header_shift;
  fail_t       first_fault;
  logic [31:0] trailer_shift;
  logic        out_valid;
  out_item_t   out_item;

  logic [15:0] idx;
  logic [31:0] crc_base, crc_next;
  logic [31:0] header_base, header_next;
  fail_t       fault_base, fault_next;
  logic [31:0] trailer_base, trailer_next;
  logic        last;
  logic [31:0] calc;
  fail_t       reason;
  logic        fire;

  always_comb begin
    // A start flag drops whatever partial record is in flight.
    idx          = item.start_of_record ? 16'd0 : byte_count;
    crc_base     = item.start_of_record ? CRC_INIT : crc_reg;
    header_base  = item.start_of_record ? 32'd0 : header_shift;
    fault_base   = item.start_of_record ? FAIL_NONE : first_fault;
    trailer_base = item.start_of_record ? 32'd0 : trailer_shift;

    crc_next     = (idx < (cfg.record_length - TRAILER_BYTES))
                   ? crc_byte(crc_base, item.data_byte) : crc_base;
    header_next  = (idx < HEADER_BYTES) ? {item.data_byte, header_base[31:8]} : header_base;
    trailer_next = {item.data_byte, trailer_base[31:8]};

    fault_next = fault_base;
    if (fault_base == FAIL_NONE) begin
      if (idx == HEADER_MAGIC_END && header_next != RECORD_MAGIC) begin
        fault_next = FAIL_MAGIC;
      end else if (idx == HEADER_END) begin
        if (header_next[15:0] != cfg.expected_version) begin
          fault_next = FAIL_VERSION;
        end else if (header_next[31:16] != cfg.record_length) begin
          fault_next = FAIL_LENGTH;
        end
      end
    end

    // Also ends the record when the length was lowered below the current position.
    last   = ({1'b0, idx} + 17'd1) >= {1'b0, cfg.record_length};
    calc   = ~crc_next;
    reason = (fault_next == FAIL_NONE && trailer_next != calc) ? FAIL_CRC : fault_next;
  end

  assign item_ready = !last || !out_valid || verdict.ready;
  assign fire       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 16'd0;
      crc_reg       <= CRC_INIT;
      header_shift  <= 32'd0;
      first_fault   <= FAIL_NONE;
      trailer_shift <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (fire && last) begin
        out_valid <= 1'b1;
      end else if (verdict.ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (last) begin
          byte_count            <= 16'd0;
          crc_reg               <= CRC_INIT;
          header_shift          <= 32'd0;
          first_fault           <= FAIL_NONE;
          trailer_shift         <= 32'd0;
          out_item.record_valid <= (reason == FAIL_NONE);
          out_item.fail_reason  <= reason;
          out_item.computed_crc <= calc;
        end else begin
          byte_count    <= idx + 16'd1;
          crc_reg       <= crc_next;
          header_shift  <= header_next;
          first_fault   <= fault_next;
          trailer_shift <= trailer_next;
        end
      end
    end
  end

  assign verdict.valid   = out_valid;
  assign verdict.payload = out_item;

  a_verdict_consistent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.record_valid == (out_item.fail_reason == FAIL_NONE)))
    else $error("record_valid disagrees with fail_reason");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    (fire && last) |=> (byte_count == 16'd0 && crc_reg == CRC_INIT && out_valid))
    else $error("record state not cleared after a verdict");

  a_count_advance: assert property (@(posedge clk) disable iff (rst)
    (fire && !last) |=> (byte_count == $past(idx) + 16'd1))
    else $error("byte count did not advance by one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !verdict.ready) |=> out_valid)
    else $error("pending verdict lost while stalled");

endmodule

`default_nettype wire

### rtl/crc32_record_validator_unit.sv
// Top level of the CRC-32 record validator: input register, config and checker.
//
// Usage:
//   rec_in carries one record byte per request (data_byte, start_of_record).
//   A start flag makes that byte byte 0 of a new record; without one, the
//   byte after reset or after a verdict is byte 0 anyway.
//   verdict carries one request per finished record (record_valid,
//   fail_reason, computed_crc), issued on the record_length-th byte.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes
//   expected_version (index 0) and record_length (index 1).
// Timing:
//   A byte is registered in the input register when accepted and folded
//   into the CRC and header state from there; the verdict is registered as
//   its last byte is folded in. One byte per cycle is sustained unless a
//   verdict stalls; the eight-bit CRC step between the registers sets that rate.
// Reset (synchronous) returns the registers to version 1, length 64, and
// clears the record state. While verdict is stalled, bytes that do not end
// a record keep flowing; a record-ending byte waits in the input register.
`timescale 1ns / 1ps
`default_nettype none

module crc32_record_validator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  crc32rv_in_if.sink                            rec_in,
  crc32rv_out_if.source                         verdict,
  input  logic                                  cfg_we,
  input  logic [crc32rv_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [15:0]                           cfg_data
);
  import crc32rv_pkg::*;

  cfg_t     cfg;
  logic     in_valid_q;
  in_item_t in_q;
  logic     item_ready;

  crc32rv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign rec_in.ready = !in_valid_q || item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (rec_in.ready) begin
      in_valid_q <= rec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_in.valid && rec_in.ready) begin
      in_q <= rec_in.payload;
    end
  end

  crc32rv_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (in_valid_q),
    .item       (in_q),
    .item_ready (item_ready),
    .verdict    (verdict)
  );

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the CRC-32 record validator: directed records, then random streams.
`timescale 1ns / 1ps

module tb;
  import crc32rv_pkg::*;

  localparam int LIMIT_CYCLES  = 200_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int TARGET_BYTES  = 1300;
  localparam int HOLD_PHASE    = 3;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct {
    bit          write_cfg;
    logic [15:0] ver_reg;
    logic [15:0] len_reg;
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] len_field;
    bit          bad_crc;
    bit          start;
    int          lead;
    int          shrink_at;
    logic [15:0] shrink_to;
    bit          typed;
    fail_t       reason;
  } rec_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [15:0] cfg_data;

  crc32rv_in_if  rec_in_bus ();
  crc32rv_out_if verdict_bus ();

  crc32_record_validator_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .rec_in    (rec_in_bus),
    .verdict   (verdict_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copy of the registers and the per-record state.
  logic [15:0] ver_reg;
  logic [15:0] len_reg;
  logic [15:0] rec_count;
  logic [31:0] rec_crc;
  logic [31:0] rec_hdr;
  fail_t       rec_fault;
  logic [31:0] rec_tail;

  out_item_t   pending_verdicts[$];
  logic [7:0]  rec_bytes[];
  int          bytes_sent;
  int          mismatches = 0;
  int          cycles = 0;
  int          hold_off = 0;
  bit          calm;

  //    cfg  ver_reg   len_reg   magic                version   len_field bad st lead shr to
  //    typed reason
  rec_row_t rows [0:10] = '{
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC,        16'd1,    16'd64,   1'b0, 1'b0, 0, 0, 16'd0,
      1'b1, FAIL_NONE},
    '{1'b1, 16'd0,     16'd12,   RECORD_MAGIC,        16'd0,    16'd12,   1'b0, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_NONE},
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC ^ 32'h1, 16'd1,   16'd12,   1'b0, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_MAGIC},
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC,        16'd1,    16'd13,   1'b0, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_VERSION},
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC,        16'd0,    16'd13,   1'b1, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_LENGTH},
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC,        16'd0,    16'd12,   1'b1, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_CRC},
    '{1'b1, 16'hFFFF,  16'd0,    RECORD_MAGIC,        16'hFFFF, 16'd12,   1'b0, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_NONE},
    '{1'b1, 16'hFFFF,  16'd11,   RECORD_MAGIC,        16'hFFFF, 16'd11,   1'b0, 1'b1, 0, 0, 16'd0,
      1'b1, FAIL_LENGTH},
    '{1'b0, 16'd0,     16'd0,    RECORD_MAGIC,        16'hFFFF, 16'd12,   1'b0, 1'b1, 5, 0, 16'd0,
      1'b1, FAIL_NONE},
    '{1'b1, 16'h1234,  16'hFFFF, RECORD_MAGIC,        16'h1234, 16'hFFFF, 1'b0, 1'b1, 0, 20, 16'd16,
      1'b0, FAIL_NONE},
    '{1'b1, 16'd0,     16'd12,   RECORD_MAGIC,        16'd0,    16'd12,   1'b0, 1'b0, 0, 0, 16'd0,
      1'b1, FAIL_NONE}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [31:0] crc_fold8(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ b[k]}});
    end
    return c;
  endfunction

  function automatic logic [15:0] record_limit();
    return (len_reg < MIN_RECORD_LENGTH) ? MIN_RECORD_LENGTH : len_reg;
  endfunction

  function automatic void clear_record_state();
    rec_count = '0;
    rec_crc   = CRC_INIT;
    rec_hdr   = '0;
    rec_fault = FAIL_NONE;
    rec_tail  = '0;
  endfunction

  // Folds one accepted byte into the shadow state; returns 1 when it ends a record.
  function automatic bit fold_byte(input logic [7:0] b, input logic s, output out_item_t v);
    logic [15:0] lim;
    logic [15:0] idx;
    lim = record_limit();
    if (s) clear_record_state();
    idx = rec_count;
    if (idx < lim - TRAILER_BYTES) rec_crc = crc_fold8(rec_crc, b);
    if (idx < HEADER_BYTES) begin
      rec_hdr = {b, rec_hdr[31:8]};
      if (idx == HEADER_MAGIC_END) begin
        if (rec_fault == FAIL_NONE && rec_hdr != RECORD_MAGIC) rec_fault = FAIL_MAGIC;
      end else if (idx == HEADER_END && rec_fault == FAIL_NONE) begin
        if (rec_hdr[15:0] != ver_reg) rec_fault = FAIL_VERSION;
        else if (rec_hdr[31:16] != lim) rec_fault = FAIL_LENGTH;
      end
    end
    rec_tail = {b, rec_tail[31:8]};
    if ({1'b0, idx} + 17'd1 >= {1'b0, lim}) begin
      v.computed_crc = ~rec_crc;
      v.fail_reason  = rec_fault;
      if (rec_fault == FAIL_NONE && rec_tail != ~rec_crc) v.fail_reason = FAIL_CRC;
      v.record_valid = (v.fail_reason == FAIL_NONE);
      clear_record_state();
      return 1'b1;
    end
    rec_count = idx + 16'd1;
    return 1'b0;
  endfunction

  // Fills rec_bytes with a record of n bytes; the trailer optionally carries a flipped bit.
  function automatic void make_record(input logic [31:0] magic, input logic [15:0] version,
                                      input logic [15:0] len_field, input int n,
                                      input bit bad_crc);
    logic [31:0] crc;
    logic [31:0] tail;
    rec_bytes = new[n];
    for (int i = 0; i < n; i++) rec_bytes[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 4; i++) rec_bytes[i] = magic[8*i +: 8];
    for (int i = 0; i < 2; i++) begin
      rec_bytes[4 + i] = version[8*i +: 8];
      rec_bytes[6 + i] = len_field[8*i +: 8];
    end
    crc = CRC_INIT;
    for (int i = 0; i < n - 4; i++) crc = crc_fold8(crc, rec_bytes[i]);
    tail = ~crc;
    if (bad_crc) tail = tail ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) rec_bytes[n - 4 + i] = tail[8*i +: 8];
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s, input bit typed,
                           input fail_t why, output bit ended);
    int gap;
    out_item_t v;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      rec_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec_in_bus.valid   <= 1'b1;
    rec_in_bus.payload <= '{data_byte: b, start_of_record: s};
    do @(posedge clk); while (rec_in_bus.ready !== 1'b1);
    bytes_sent++;
    ended = fold_byte(b, s, v);
    if (ended) begin
      if (typed) begin
        v.record_valid = (why == FAIL_NONE);
        v.fail_reason  = why;
      end
      pending_verdicts.push_back(v);
    end
  endtask

  // Stops offering bytes until every verdict is in and the pipeline has drained.
  task automatic settle();
    rec_in_bus.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_EXPECTED_VERSION) ver_reg = val;
    else if (idx == CFG_RECORD_LENGTH) len_reg = val;
  endtask

  task automatic send_record(input logic [31:0] magic, input logic [15:0] version,
                             input logic [15:0] len_field, input bit bad_crc, input bit s,
                             input int lead, input int shrink_at, input logic [15:0] shrink_to,
                             input bit typed, input fail_t why);
    bit ended;
    make_record(magic, version, len_field, int'(record_limit()), bad_crc);
    for (int i = 0; i < lead; i++)
      push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, FAIL_NONE, ended);
    for (int i = 0; i < rec_bytes.size(); i++) begin
      if (shrink_at > 0 && i == shrink_at) begin
        settle();
        write_reg(CFG_RECORD_LENGTH, shrink_to);
        cfg_we <= 1'b0;
      end
      push_byte(rec_bytes[i], s && i == 0, typed, why, ended);
      if (ended) break;
    end
  endtask

  // Mostly clean records; now and then header fields or the trailer are corrupted, each on its own.
  task automatic send_random_record();
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] len_field;
    magic     = RECORD_MAGIC;
    version   = ver_reg;
    len_field = record_limit();
    if ($urandom_range(0, 9) == 0) magic = magic ^ (32'd1 << $urandom_range(0, 31));
    if ($urandom_range(0, 7) == 0) version = 16'($urandom);
    if ($urandom_range(0, 7) == 0) len_field = 16'($urandom);
    send_record(magic, version, len_field, $urandom_range(0, 5) == 0,
                rec_count != 0 || $urandom_range(0, 1) == 1, 0, 0, 16'd0, 1'b0, FAIL_NONE);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return 16'($urandom_range(0, 11));
      4, 5, 6:    return 16'($urandom_range(25, 80));
      7:          return 16'($urandom_range(200, 400));
      default:    return 16'($urandom_range(12, 24));
    endcase
  endfunction

  function automatic logic [15:0] pick_version();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst === 1'b0 && verdict_bus.valid === 1'b1 && verdict_bus.ready === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with no record pending: %p", verdict_bus.payload);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        if (verdict_bus.payload.record_valid !== want.record_valid) begin
          $error("record_valid: expected %0d, got %0d", want.record_valid,
                 verdict_bus.payload.record_valid);
          mismatches++;
        end
        if (verdict_bus.payload.fail_reason !== want.fail_reason) begin
          $error("fail_reason: expected %0d, got %0d", want.fail_reason,
                 verdict_bus.payload.fail_reason);
          mismatches++;
        end
        if (verdict_bus.payload.computed_crc !== want.computed_crc) begin
          $error("computed_crc: expected %08h, got %08h", want.computed_crc,
                 verdict_bus.payload.computed_crc);
          mismatches++;
        end
      end
    end
  end

  // Verdict side: random back-pressure, plus one long hold when the stimulus asks for it.
  initial begin : verdict_sink
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    verdict_bus.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_off > 0 && !hold_done) begin
        gap       = hold_off;
        hold_done = 1'b1;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 6);
      end
      if (gap > 0) begin
        verdict_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      verdict_bus.ready <= 1'b1;
      do @(posedge clk); while (verdict_bus.valid !== 1'b1);
    end
  end

  initial begin : stimulus
    int  phase;
    int  nrec;
    int  r;
    int  j;
    bit  ended;
    bytes_sent = 0;
    calm       = 1'b0;
    ver_reg    = 16'd1;
    len_reg    = 16'd64;
    clear_record_state();
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_EXPECTED_VERSION;
    cfg_data           <= '0;
    rec_in_bus.valid   <= 1'b0;
    rec_in_bus.payload <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].write_cfg) begin
        settle();
        write_reg(CFG_EXPECTED_VERSION, rows[i].ver_reg);
        write_reg(CFG_RECORD_LENGTH, rows[i].len_reg);
        cfg_we <= 1'b0;
      end
      send_record(rows[i].magic, rows[i].version, rows[i].len_field, rows[i].bad_crc,
                  rows[i].start, rows[i].lead, rows[i].shrink_at, rows[i].shrink_to,
                  rows[i].typed, rows[i].reason);
    end

    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      settle();
      if (phase == HOLD_PHASE) begin
        write_reg(CFG_RECORD_LENGTH, MIN_RECORD_LENGTH);
      end else begin
        if ($urandom_range(0, 3) != 0) write_reg(CFG_EXPECTED_VERSION, pick_version());
        if ($urandom_range(0, 3) != 0) write_reg(CFG_RECORD_LENGTH, pick_length());
      end
      if (phase == 0 || $urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
      cfg_we <= 1'b0;
      // An open record seen under a new length: the next byte may close it at once.
      if (rec_count != 0 && $urandom_range(0, 1) == 1)
        push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, FAIL_NONE, ended);
      calm = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) hold_off = HOLD_CYCLES;
      nrec = (phase == HOLD_PHASE) ? 10 : $urandom_range(2, 6);
      for (int k = 0; k < nrec; k++) begin
        r = (phase == HOLD_PHASE) ? 0 : $urandom_range(0, 9);
        if (r == 7) begin
          j = $urandom_range(1, 20);
          for (int i = 0; i < j; i++)
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0, FAIL_NONE,
                      ended);
        end else begin
          if (r == 8) begin
            // A record cut short by the next start flag.
            j = $urandom_range(1, 9);
            for (int i = 0; i < j; i++)
              push_byte(8'($urandom_range(0, 255)), i == 0, 1'b0, FAIL_NONE, ended);
          end
          if (r == 9) settle();
          send_random_record();
        end
      end
      phase++;
    end

    settle();
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
